>>> sv/assert_macros.svh
// Assertion macros for the RTL files that check their own logic; the top level uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/tses_pkg.sv
// Package: types, constants and defaults of the timer effect engine.
package tses_pkg;

  localparam int CHIP_COUNT_DEF   = 3;
  localparam int SAMPLE_COUNT_DEF = 32;
  localparam int SAMPLE_DEPTH_DEF = 4096;

  localparam int VOICES_PER_CHIP = 3;
  localparam logic [1:0] VOICE_LAST = 2'd2;

  localparam int PREDIV_NUM = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] PREDIV_RST [PREDIV_NUM] =
    '{8'd4, 8'd10, 8'd16, 8'd50, 8'd64, 8'd100, 8'd200};

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;
  localparam logic [1:0] CMD_LEN   = 2'd3;

  localparam logic [4:0] LEVEL_MAX = 5'd15;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  chip_index;
    logic [7:0]  sid_flag;
    logic [7:0]  drum_flag;
    logic [7:0]  sid_timer;
    logic [7:0]  reg_eight;
    logic [7:0]  reg_nine;
    logic [7:0]  reg_ten;
    logic [7:0]  sid_count;
    logic [7:0]  drum_count;
    logic [16:0] load_address;
    logic [12:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_chip;
    logic [1:0] out_voice;
    logic [3:0] out_level;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic        active;
    logic [3:0]  level;
    logic [15:0] reload;
    logic [15:0] phase;
    logic        toggle;
  } sq_state_t;

  typedef struct packed {
    logic        active;
    logic [15:0] reload;
    logic [15:0] phase;
    logic [12:0] position;
    logic [4:0]  sample;
  } dr_state_t;

  typedef struct packed {
    sq_state_t sq;
    dr_state_t dr;
  } voice_state_t;

  // Voice memory: lane write enables and read enable.
  typedef struct packed {
    logic sq_we;
    logic dr_we;
    logic rd_en;
  } vm_ctrl_t;

  // Sample store: byte load, length load, playback read.
  typedef struct packed {
    logic byte_we;
    logic len_we;
    logic rd_en;
  } smem_ctrl_t;

  typedef struct packed {
    logic push;
    logic flush;
  } rb_ctrl_t;

  typedef struct packed {
    logic ok;
    logic hold_v;
  } rb_stat_t;

endpackage

>>> sv/tses_stream_if.sv
// Valid/ready stream interface carrying one payload item per transfer.
interface tses_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/tses_voice_mem.sv
// Per-voice state memory with square and drum write lanes and reset valid bits.
module tses_voice_mem #(
  parameter int DEPTH = 9,
  parameter int AW    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tses_pkg::vm_ctrl_t     ctrl,
  input  logic [AW-1:0]          waddr,
  input  logic [AW-1:0]          raddr,
  input  tses_pkg::voice_state_t wdata,
  output tses_pkg::voice_state_t rdata
);
  import tses_pkg::*;

  voice_state_t     voice_mem [DEPTH];
  voice_state_t     rd_raw_r;
  logic [DEPTH-1:0] sq_vld_r;
  logic [DEPTH-1:0] dr_vld_r;
  logic             sq_ok_r;
  logic             dr_ok_r;

  always_ff @(posedge clk) begin
    if (ctrl.sq_we) begin
      voice_mem[waddr].sq <= wdata.sq;
    end
    if (ctrl.dr_we) begin
      voice_mem[waddr].dr <= wdata.dr;
    end
    if (ctrl.rd_en) begin
      rd_raw_r <= voice_mem[raddr];
      sq_ok_r  <= sq_vld_r[raddr];
      dr_ok_r  <= dr_vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= '0;
      dr_vld_r <= '0;
    end else begin
      if (ctrl.sq_we) begin
        sq_vld_r[waddr] <= 1'b1;
      end
      if (ctrl.dr_we) begin
        dr_vld_r[waddr] <= 1'b1;
      end
    end
  end

  // A lane never written since reset reads as all zero.
  assign rdata.sq = sq_ok_r ? rd_raw_r.sq : '0;
  assign rdata.dr = dr_ok_r ? rd_raw_r.dr : '0;

endmodule

>>> sv/tses_sample_mem.sv
// Sample store: nibble memory for drum samples plus the per-sample length table.
module tses_sample_mem #(
  parameter int SAMPLE_COUNT = 32,
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tses_pkg::smem_ctrl_t ctrl,
  input  logic [4:0]           ld_sample,
  input  logic [11:0]          ld_pos,
  input  logic [12:0]          ld_value,
  input  logic [4:0]           rd_sample,
  input  logic [12:0]          rd_pos,
  output logic [3:0]           rd_nibble,
  output logic [12:0]          rd_len
);
  import tses_pkg::*;

  localparam int SW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int PW = $clog2(SAMPLE_DEPTH);
  localparam int AW = SW + PW;

  // Only the low nibble of a sample byte is ever played.
  logic [3:0]  sample_mem [1 << AW];
  logic [12:0] len_r [SAMPLE_COUNT];
  logic [3:0]  rd_data_r;
  logic        rd_zero_r;

  logic [15:0]   ld_pos_x;
  logic [15:0]   rd_pos_x;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          ld_s_ok;
  logic          ld_p_ok;
  logic          rd_s_ok;
  logic          rd_p_ok;

  assign ld_pos_x = {4'd0, ld_pos};
  assign rd_pos_x = {3'd0, rd_pos};
  assign waddr    = {ld_sample[SW-1:0], ld_pos_x[PW-1:0]};
  assign raddr    = {rd_sample[SW-1:0], rd_pos_x[PW-1:0]};
  assign ld_s_ok  = 32'(ld_sample) < SAMPLE_COUNT;
  assign ld_p_ok  = 32'(ld_pos) < SAMPLE_DEPTH;
  assign rd_s_ok  = 32'(rd_sample) < SAMPLE_COUNT;
  assign rd_p_ok  = 32'(rd_pos) < SAMPLE_DEPTH;

  always_ff @(posedge clk) begin
    if (ctrl.byte_we && ld_s_ok && ld_p_ok) begin
      sample_mem[waddr] <= ld_value[3:0];
    end
    if (ctrl.rd_en) begin
      rd_data_r <= sample_mem[raddr];
      rd_zero_r <= !(rd_s_ok && rd_p_ok);
    end
  end

  assign rd_nibble = rd_zero_r ? 4'd0 : rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SAMPLE_COUNT; k++) begin
        len_r[k] <= '0;
      end
    end else if (ctrl.len_we && ld_s_ok) begin
      len_r[ld_sample[SW-1:0]] <= ld_value;
    end
  end

  assign rd_len = rd_s_ok ? len_r[rd_sample[SW-1:0]] : 13'd0;

endmodule

>>> sv/tses_result_buf.sv
// Result path: one-entry hold stage that resolves the last flag, then the output register.
module tses_result_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  tses_pkg::rb_ctrl_t  ctrl,
  input  tses_pkg::out_item_t res,
  output tses_pkg::rb_stat_t  stat,
  tses_stream_if.source       out_item
);
  import tses_pkg::*;

  out_item_t hold_r;
  out_item_t out_r;
  logic      hold_v_r;
  logic      hold_v_nxt;
  logic      out_v_r;
  logic      out_v_nxt;
  logic      out_free;
  logic      load_out;
  logic      out_last;

  assign out_free    = !out_v_r || out_item.ready;
  assign stat.ok     = !hold_v_r || out_free;
  assign stat.hold_v = hold_v_r;

  // A held result only leaves once the next one arrives or the tick ends,
  // so its last flag is known when it moves to the output register.
  always_comb begin
    hold_v_nxt = hold_v_r;
    out_v_nxt  = out_v_r && !out_item.ready;
    load_out   = 1'b0;
    out_last   = 1'b0;
    if (ctrl.push && stat.ok) begin
      hold_v_nxt = 1'b1;
      load_out   = hold_v_r;
    end else if (ctrl.flush && stat.ok && hold_v_r) begin
      hold_v_nxt = 1'b0;
      load_out   = 1'b1;
      out_last   = 1'b1;
    end
    if (load_out) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && stat.ok) begin
      hold_r <= res;
    end
    if (load_out) begin
      out_r <= '{out_chip:  hold_r.out_chip,
                 out_voice: hold_r.out_voice,
                 out_level: hold_r.out_level,
                 last:      out_last};
    end
  end

  assign out_item.valid = out_v_r;
  assign out_item.data  = out_r;

endmodule

>>> sv/timer_synth_effect_engine_top.sv
// Timer effect engine top level: item sequencer, predivisor registers, checks.
//
// in_item carries commands: frame decode, tick, sample byte load, sample
// length load. out_item carries one level write per transfer (chip, voice,
// level, last); only ticks produce results, last marks the final one.
// cfg_we/cfg_index/cfg_data write predivisor registers 0..6, index 7 is ignored.
//
// A tick reads each voice from the voice state memory, updates and writes
// it back in S_CALC and then waits in S_DRM for the sample memory read
// of a drum nibble; these two steps per voice and result stalls set the tick rate.
// Results leave through a hold stage and an output register: a write of a
// tick becomes visible when the next write arrives or when the tick ends.
// A stalled receiver stops the voice walk only when both result stages are
// full; ready stays low until the tick's results have all entered them.
// Reset: predivisors return to 4,10,16,50,64,100,200; voice state and sample
// lengths read as zero; sample bytes are undefined until loaded.
`include "assert_macros.svh"

module timer_synth_effect_engine_top #(
  parameter int CHIP_COUNT   = tses_pkg::CHIP_COUNT_DEF,
  parameter int SAMPLE_COUNT = tses_pkg::SAMPLE_COUNT_DEF,
  parameter int SAMPLE_DEPTH = tses_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tses_stream_if.sink                     in_item,
  tses_stream_if.source                   out_item,
  input  logic                            cfg_we,
  input  logic [tses_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tses_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tses_pkg::*;

  localparam int VOICES = CHIP_COUNT * VOICES_PER_CHIP;
  localparam int VW     = $clog2(VOICES);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FSQ  = 8'b0000_0010,
    S_FDR  = 8'b0000_0100,
    S_LOAD = 8'b0000_1000,
    S_TRD  = 8'b0001_0000,
    S_CALC = 8'b0010_0000,
    S_DRM  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } seq_state_t;

  seq_state_t    state_r;
  seq_state_t    state_nxt;
  in_item_t      item_r;
  logic [VW-1:0] idx_r;
  logic [VW-1:0] idx_nxt;
  logic [1:0]    chip_r;
  logic [1:0]    chip_nxt;
  logic [1:0]    vc_r;
  logic [1:0]    vc_nxt;
  logic          dr_fire_r;
  logic          dr_fire_nxt;
  logic [7:0]    prediv_r [PREDIV_NUM];

  vm_ctrl_t      vm_ctrl;
  logic [VW-1:0] vm_waddr;
  logic [VW-1:0] vm_raddr;
  voice_state_t  vm_wdata;
  voice_state_t  vm_rdata;

  smem_ctrl_t    sm_ctrl;
  logic [3:0]    sm_nibble;
  logic [12:0]   sm_len;

  rb_ctrl_t      rb_ctrl;
  rb_stat_t      rb_stat;
  out_item_t     res;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PREDIV_NUM; k++) begin
        prediv_r[k] <= PREDIV_RST[k];
      end
    end else if (cfg_we && 32'(cfg_index) < PREDIV_NUM) begin
      prediv_r[cfg_index] <= cfg_data;
    end
  end

  // ---------------------------------------------------------- frame decode
  // One multiplier serves the square slot in S_FSQ and the drum slot in S_FDR.
  logic         f_drum;
  logic [7:0]   f_timer;
  logic [7:0]   f_count;
  logic [7:0]   f_flag;
  logic [2:0]   f_code;
  logic [1:0]   f_vb;
  logic [7:0]   f_mult;
  logic [8:0]   f_cnt1;
  logic [16:0]  f_prod;
  logic         f_chip_ok;
  logic         f_trig;
  logic [4:0]   f_vidx;
  logic [7:0]   f_samp_reg;
  voice_state_t frame_state;

  assign f_drum    = (state_r == S_FDR);
  assign f_timer   = f_drum ? item_r.reg_eight : item_r.sid_timer;
  assign f_count   = f_drum ? item_r.drum_count : item_r.sid_count;
  assign f_flag    = f_drum ? item_r.drum_flag : item_r.sid_flag;
  assign f_code    = f_timer[7:5];
  assign f_vb      = f_flag[5:4];
  assign f_mult    = (f_code == 3'd0) ? 8'd0 : prediv_r[f_code - 3'd1];
  assign f_cnt1    = {1'b0, f_count} + 9'd1;
  assign f_prod    = 17'(f_cnt1) * 17'(f_mult);
  assign f_chip_ok = 32'(item_r.chip_index) < CHIP_COUNT;
  assign f_trig    = f_chip_ok && (f_vb != 2'd0) && (f_prod != 17'd0);
  assign f_vidx    = 5'(item_r.chip_index) * 5'd3 + 5'(f_vb) - 5'd1;

  always_comb begin
    unique case (f_vb)
      2'd2:    f_samp_reg = item_r.reg_nine;
      2'd3:    f_samp_reg = item_r.reg_ten;
      default: f_samp_reg = item_r.reg_eight;
    endcase
  end

  always_comb begin
    frame_state.sq.active   = 1'b1;
    frame_state.sq.level    = (item_r.sid_count[4:0] > LEVEL_MAX) ? LEVEL_MAX[3:0]
                                                                  : item_r.sid_count[3:0];
    frame_state.sq.reload   = f_prod[15:0];
    frame_state.sq.phase    = f_prod[15:0];
    frame_state.sq.toggle   = 1'b0;
    frame_state.dr.active   = 1'b1;
    frame_state.dr.reload   = f_prod[15:0];
    frame_state.dr.phase    = f_prod[15:0];
    frame_state.dr.position = 13'd0;
    frame_state.dr.sample   = f_samp_reg[4:0];
  end

  // ------------------------------------------------------------ tick update
  logic         sq_fire;
  logic         dr_fire;
  logic [15:0]  sq_ph;
  logic [15:0]  dr_ph;
  logic [12:0]  dr_pos_n;
  logic [3:0]   sq_level;
  voice_state_t calc_state;

  assign sq_ph    = vm_rdata.sq.phase - 16'd1;
  assign dr_ph    = vm_rdata.dr.phase - 16'd1;
  assign sq_fire  = vm_rdata.sq.active && (sq_ph == 16'd0);
  assign dr_fire  = vm_rdata.dr.active && (dr_ph == 16'd0);
  assign dr_pos_n = vm_rdata.dr.position + 13'd1;

  always_comb begin
    calc_state = vm_rdata;
    if (vm_rdata.sq.active) begin
      calc_state.sq.phase = sq_fire ? vm_rdata.sq.reload : sq_ph;
    end
    if (sq_fire) begin
      calc_state.sq.toggle = !vm_rdata.sq.toggle;
    end
    if (vm_rdata.dr.active) begin
      calc_state.dr.phase = dr_fire ? vm_rdata.dr.reload : dr_ph;
    end
    if (dr_fire) begin
      calc_state.dr.position = dr_pos_n;
      calc_state.dr.active   = dr_pos_n < sm_len;
    end
  end

  assign sq_level = calc_state.sq.toggle ? vm_rdata.sq.level : 4'd0;

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    chip_nxt    = chip_r;
    vc_nxt      = vc_r;
    dr_fire_nxt = dr_fire_r;
    vm_ctrl     = '0;
    vm_waddr    = idx_r;
    vm_raddr    = idx_r;
    vm_wdata    = calc_state;
    sm_ctrl     = '0;
    rb_ctrl     = '0;
    res.out_chip  = chip_r;
    res.out_voice = vc_r;
    res.out_level = sq_level;
    res.last      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          idx_nxt  = '0;
          chip_nxt = 2'd0;
          vc_nxt   = 2'd0;
          unique case (in_item.data.command)
            CMD_FRAME: state_nxt = S_FSQ;
            CMD_TICK:  state_nxt = S_TRD;
            default:   state_nxt = S_LOAD;
          endcase
        end
      end
      S_FSQ: begin
        vm_ctrl.sq_we = f_trig;
        vm_waddr      = f_vidx[VW-1:0];
        vm_wdata      = frame_state;
        state_nxt     = S_FDR;
      end
      S_FDR: begin
        vm_ctrl.dr_we = f_trig;
        vm_waddr      = f_vidx[VW-1:0];
        vm_wdata      = frame_state;
        state_nxt     = S_IDLE;
      end
      S_LOAD: begin
        sm_ctrl.byte_we = (item_r.command == CMD_BYTE);
        sm_ctrl.len_we  = (item_r.command == CMD_LEN);
        state_nxt       = S_IDLE;
      end
      S_TRD: begin
        vm_ctrl.rd_en = 1'b1;
        state_nxt     = S_CALC;
      end
      S_CALC: begin
        rb_ctrl.push = sq_fire;
        if (!sq_fire || rb_stat.ok) begin
          vm_ctrl.sq_we = 1'b1;
          vm_ctrl.dr_we = 1'b1;
          sm_ctrl.rd_en = 1'b1;
          dr_fire_nxt   = dr_fire;
          state_nxt     = S_DRM;
        end
      end
      S_DRM: begin
        rb_ctrl.push  = dr_fire_r;
        res.out_level = sm_nibble;
        if (!dr_fire_r || rb_stat.ok) begin
          if (idx_r == VW'(VOICES - 1)) begin
            state_nxt = S_FIN;
          end else begin
            vm_ctrl.rd_en = 1'b1;
            vm_raddr      = idx_r + VW'(1);
            idx_nxt       = idx_r + VW'(1);
            if (vc_r == VOICE_LAST) begin
              vc_nxt   = 2'd0;
              chip_nxt = chip_r + 2'd1;
            end else begin
              vc_nxt = vc_r + 2'd1;
            end
            state_nxt = S_CALC;
          end
        end
      end
      S_FIN: begin
        rb_ctrl.flush = 1'b1;
        if (rb_stat.ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      chip_r    <= 2'd0;
      vc_r      <= 2'd0;
      dr_fire_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      chip_r    <= chip_nxt;
      vc_r      <= vc_nxt;
      dr_fire_r <= dr_fire_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      item_r <= in_item.data;
    end
  end

  assign in_item.ready = (state_r == S_IDLE);

  // ------------------------------------------------------------- instances
  tses_voice_mem #(
    .DEPTH (VOICES),
    .AW    (VW)
  ) u_voice_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (vm_ctrl),
    .waddr (vm_waddr),
    .raddr (vm_raddr),
    .wdata (vm_wdata),
    .rdata (vm_rdata)
  );

  tses_sample_mem #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_sample_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (sm_ctrl),
    .ld_sample (item_r.load_address[16:12]),
    .ld_pos    (item_r.load_address[11:0]),
    .ld_value  (item_r.load_value),
    .rd_sample (vm_rdata.dr.sample),
    .rd_pos    (vm_rdata.dr.position),
    .rd_nibble (sm_nibble),
    .rd_len    (sm_len)
  );

  tses_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (rb_ctrl),
    .res      (res),
    .stat     (rb_stat),
    .out_item (out_item)
  );

  // ------------------------------------------------------------ assertions
  `ASSERT_IMPL(a_idle_hold_empty, clk, rst_n, in_item.ready, !rb_stat.hold_v)
  `ASSERT_IMPL(a_vm_no_rd_wr, clk, rst_n, vm_ctrl.rd_en, !(vm_ctrl.sq_we || vm_ctrl.dr_we))
  `ASSERT_IMPL(a_idx_range, clk, rst_n, (state_r == S_CALC) || (state_r == S_DRM), idx_r <= VW'(VOICES - 1))
  `ASSERT_NEXT(a_push_moves_out, clk, rst_n, rb_ctrl.push && rb_stat.ok && rb_stat.hold_v, out_item.valid)

endmodule
